// File: src/llgt_pkg.sv
// shared types and constants for the least-loaded gateway table
`timescale 1ns / 1ps
package llgt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [15:0] FULL_MARGIN = 16'd10;
    localparam logic [15:0] MGU_RESET   = 16'd2000;

    localparam logic [2:0] FN_PUT         = 3'd0;
    localparam logic [2:0] FN_DISABLE_ALL = 3'd1;
    localparam logic [2:0] FN_DISABLE_ZN  = 3'd2;
    localparam logic [2:0] FN_SELECT      = 3'd3;
    localparam logic [2:0] FN_VERIFY      = 3'd4;

    localparam logic [1:0] GS_AVAIL  = 2'd0;
    localparam logic [1:0] GS_MAINT  = 2'd1;
    localparam logic [1:0] GS_NMAINT = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NOT_OPEN  = 3'd1;
    localparam logic [2:0] STS_NMAINT    = 3'd2;
    localparam logic [2:0] STS_VER_ERR   = 3'd3;
    localparam logic [2:0] STS_FULL      = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] zone_id;
        logic [15:0] server_id;
        logic [15:0] net_type;
        logic [1:0]  gw_state;
        logic [15:0] online_count;
        logic [15:0] port_number;
        logic [31:0] game_version;
        logic [31:0] client_version;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] out_server_id;
        logic [15:0] out_net_type;
        logic [15:0] out_port;
        logic [15:0] out_online;
        logic [2:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [31:0] zone;
        logic [15:0] server;
        logic [15:0] net_type;
        logic [1:0]  state;
        logic [15:0] online;
        logic [15:0] port;
        logic [31:0] version;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// File: src/llgt_if.sv
// handshake channel interfaces for the gateway table
`timescale 1ns / 1ps
interface llgt_req_if;
    import llgt_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface llgt_rsp_if;
    import llgt_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface llgt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/least_loaded_gateway_table.sv
// least-loaded gateway table: sequencer, entry memory and shared compare unit
//
//   channel | dir | beat
//   req     | in  | func, zone, server, net type, state, online, port, versions
//   rsp     | out | found, server, net type, port, online, status
//   cfg     | in  | max_gateway_users
//
// one request at a time; a scan reads one entry per cycle
// a put scans and then writes; verify and disable scan once; select may scan a second time
// the registered entry memory read sets the pace
// reset empties the table; entries are never cleared, only the fill count
// a stalled response holds the block until it is taken
`timescale 1ns / 1ps
module least_loaded_gateway_table
    import llgt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    llgt_req_if.sink   req,
    llgt_rsp_if.source rsp,
    llgt_cfg_if.sink   cfg
);

    entry_t mem [TABLE_DEPTH];

    state_t            state_reg, state_next;
    req_t              req_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              dv_reg, dv_next;
    logic [IDX_W-1:0]  didx_reg, didx_next;
    entry_t            rd_data_reg;
    logic              pass_reg, pass_next;
    logic              best_vld_reg, best_vld_next;
    entry_t            best_reg, best_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              nm_reg, nm_next;
    rsp_t              rsp_reg, rsp_next;
    logic [15:0]       mgu_reg;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    entry_t            wdata;
    logic [IDX_W-1:0]  raddr;
    logic [15:0]       thr;
    logic              scan_done;
    logic              zone_eq;
    logic              is_dis;
    logic              cand;
    logic              accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_DONE);
    assign rsp.data  = rsp_reg;
    assign cfg.ready = 1'b1;

    assign thr       = (mgu_reg < FULL_MARGIN) ? 16'd0 : mgu_reg - FULL_MARGIN;
    assign scan_done = (issue_reg == cnt_reg) && !dv_reg;
    assign zone_eq   = (rd_data_reg.zone == req_reg.zone_id);
    assign is_dis    = (req_reg.func == FN_DISABLE_ALL) || (req_reg.func == FN_DISABLE_ZN);
    assign cand      = zone_eq && (rd_data_reg.state == GS_AVAIL)
                       && (pass_reg || req_reg.func != FN_SELECT
                           || rd_data_reg.net_type == req_reg.net_type);
    assign raddr     = issue_reg[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.func > FN_VERIFY)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    if (req_reg.func == FN_PUT)
                        state_next = (!hit_reg && cnt_reg == CNT_W'(TABLE_DEPTH))
                                     ? ST_DONE : ST_WRITE;
                    else if (req_reg.func == FN_SELECT && !pass_reg
                             && !(best_vld_reg && best_reg.online < thr))
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and sequencer outputs
    always_comb
    begin
        cnt_next      = cnt_reg;
        issue_next    = issue_reg;
        dv_next       = 1'b0;
        didx_next     = didx_reg;
        pass_next     = pass_reg;
        best_vld_next = best_vld_reg;
        best_next     = best_reg;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        nm_next       = nm_reg;
        rsp_next      = rsp_reg;
        we            = 1'b0;
        waddr         = didx_reg;
        wdata         = rd_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    issue_next    = '0;
                    pass_next     = 1'b0;
                    best_vld_next = 1'b0;
                    hit_next      = 1'b0;
                    nm_next       = 1'b0;
                    rsp_next      = '0;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg != cnt_reg)
                begin
                    issue_next = issue_reg + 1'b1;
                    dv_next    = 1'b1;
                    didx_next  = issue_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    if (cand && (!best_vld_reg || best_reg.online >= rd_data_reg.online))
                    begin
                        best_vld_next = 1'b1;
                        best_next     = rd_data_reg;
                    end
                    if (zone_eq && rd_data_reg.state == GS_NMAINT)
                        nm_next = 1'b1;
                    if (zone_eq && rd_data_reg.server == req_reg.server_id && !hit_reg)
                    begin
                        hit_next  = 1'b1;
                        slot_next = didx_reg;
                    end
                    if (is_dis && (req_reg.func == FN_DISABLE_ALL || zone_eq))
                    begin
                        we           = 1'b1;
                        wdata.port   = '0;
                        wdata.online = '0;
                        if (rd_data_reg.state != GS_NMAINT)
                            wdata.state = GS_MAINT;
                    end
                end
                if (scan_done)
                begin
                    unique case (req_reg.func)
                        FN_PUT:
                        begin
                            if (!hit_reg)
                            begin
                                slot_next = cnt_reg[IDX_W-1:0];
                                if (cnt_reg == CNT_W'(TABLE_DEPTH))
                                    rsp_next.status = STS_FULL;
                            end
                        end
                        FN_SELECT:
                        begin
                            if (best_vld_reg && best_reg.online < thr)
                            begin
                                rsp_next.found         = 1'b1;
                                rsp_next.out_server_id = best_reg.server;
                                rsp_next.out_net_type  = best_reg.net_type;
                                rsp_next.out_port      = best_reg.port;
                                rsp_next.out_online    = best_reg.online;
                            end
                            else if (!pass_reg)
                            begin
                                pass_next     = 1'b1;
                                issue_next    = '0;
                                dv_next       = 1'b0;
                                best_vld_next = 1'b0;
                            end
                        end
                        FN_VERIFY:
                        begin
                            if (!best_vld_reg)
                                rsp_next.status = nm_reg ? STS_NMAINT : STS_NOT_OPEN;
                            else if (best_reg.version != '0
                                     && best_reg.version != req_reg.client_version)
                                rsp_next.status = STS_VER_ERR;
                            else
                                rsp_next.found = 1'b1;
                        end
                        default: rsp_next = rsp_reg;
                    endcase
                end
            end
            ST_WRITE:
            begin
                we             = 1'b1;
                waddr          = slot_reg;
                wdata.zone     = req_reg.zone_id;
                wdata.server   = req_reg.server_id;
                wdata.net_type = req_reg.net_type;
                wdata.state    = req_reg.gw_state;
                wdata.online   = req_reg.online_count;
                wdata.port     = req_reg.port_number;
                wdata.version  = req_reg.game_version;
                if (!hit_reg)
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req.data;
        didx_reg <= didx_next;
        best_reg <= best_next;
        slot_reg <= slot_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            issue_reg    <= '0;
            dv_reg       <= 1'b0;
            pass_reg     <= 1'b0;
            best_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            nm_reg       <= 1'b0;
            mgu_reg      <= MGU_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            issue_reg    <= issue_next;
            dv_reg       <= dv_next;
            pass_reg     <= pass_next;
            best_vld_reg <= best_vld_next;
            hit_reg      <= hit_next;
            nm_reg       <= nm_next;
            if (cfg.valid)
                mgu_reg <= cfg.data;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_WRITE |=> cnt_reg == $past(cnt_reg))
        else $error("fill count changed outside a put write");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg <= cnt_reg)
        else $error("scan index passed fill count");

    a_full_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (hit_reg || cnt_reg != CNT_W'(TABLE_DEPTH)))
        else $error("append into full table");

endmodule
